// ----- sv/smap_pkg.sv -----
package smap_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int MAX_LINE    = 4096;

    localparam int WIN_DEPTH = MAX_PATTERN - 1;
    localparam int IDX_W     = $clog2(MAX_PATTERN);
    localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
    localparam int PAT_W     = 8 * MAX_PATTERN;
    localparam int POS_W     = 12;
    localparam int CFG_W     = 64;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

    // register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PAT_LO  = 2'd0;
    localparam t_cfg_idx CFG_PAT_HI  = 2'd1;
    localparam t_cfg_idx CFG_PAT_LEN = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } t_in_req;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] match_start;
        logic             line_done;
    } t_out_req;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// ----- sv/smap_cell.sv -----
module smap_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smap_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_pat_byte,
    input  logic                i_active,
    output logic [7:0]          o_byte,
    output logic                o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.clear) begin
            n_byte = '0;
        end else if (i_ctl.shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    // cells beyond the pattern length always pass
    assign o_hit  = !i_active || (r_byte == i_pat_byte);
    assign o_byte = r_byte;

endmodule

// ----- sv/substring_match_all_positions_core.sv -----
// A request's result is loaded into the output register when it is accepted.
// Throughput: one byte per cycle unless stalled; all window cells compare in parallel.
// The output register is the only stage, so a held result stalls input only
// when it is not taken in the same cycle.
// Reset (synchronous, active low): window cleared, position 0, pattern zero, length 1.
module substring_match_all_positions_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  smap_pkg::t_in_req        i_in_req,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output smap_pkg::t_out_req       o_out_req,
    input  logic                     i_cfg_we,
    input  smap_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [smap_pkg::CFG_W-1:0] i_cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration: pattern bytes and clamped length (1..MAX_PATTERN)
    // ---------------------------------------------------------------
    logic [smap_pkg::PAT_W-1:0] r_pat;
    logic [smap_pkg::PAT_W-1:0] n_pat;
    logic [smap_pkg::LEN_W-1:0] r_len;
    logic [smap_pkg::LEN_W-1:0] n_len;
    logic [smap_pkg::LEN_W-1:0] w_len_wr;

    always_comb begin
        w_len_wr = i_cfg_wdata[smap_pkg::LEN_W-1:0];
        // zero acts as one; anything above the max saturates
        if (w_len_wr == '0) begin
            w_len_wr = smap_pkg::LEN_W'(1);
        end else if (w_len_wr > smap_pkg::LEN_W'(smap_pkg::MAX_PATTERN)) begin
            w_len_wr = smap_pkg::LEN_W'(smap_pkg::MAX_PATTERN);
        end
    end

    always_comb begin
        n_pat = r_pat;
        n_len = r_len;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                smap_pkg::CFG_PAT_LO: begin
                    n_pat[smap_pkg::PAT_W/2-1:0] = i_cfg_wdata;
                end
                smap_pkg::CFG_PAT_HI: begin
                    n_pat[smap_pkg::PAT_W-1:smap_pkg::PAT_W/2] = i_cfg_wdata;
                end
                smap_pkg::CFG_PAT_LEN: begin
                    n_len = w_len_wr;
                end
                default: begin
                    // unmapped index: write is dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= smap_pkg::LEN_W'(1);
        end else begin
            r_pat <= n_pat;
            r_len <= n_len;
        end
    end

    // length minus one: index of the pattern's last byte
    logic [smap_pkg::IDX_W-1:0] w_lenm1;
    assign w_lenm1 = smap_pkg::IDX_W'(r_len - smap_pkg::LEN_W'(1));

    // ---------------------------------------------------------------
    // Handshake and position counter
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic n_out_valid;
    logic w_in_acc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    smap_pkg::t_cell_ctl w_ctl;
    assign w_ctl.shift = w_in_acc && !i_in_req.end_of_line;
    assign w_ctl.clear = w_in_acc && i_in_req.end_of_line;

    logic [smap_pkg::POS_W-1:0] r_pos;
    logic [smap_pkg::POS_W-1:0] n_pos;

    always_comb begin
        n_pos = r_pos;
        if (w_ctl.clear) begin
            n_pos = '0;
        end else if (w_ctl.shift && (r_pos != smap_pkg::POS_MAX)) begin
            n_pos = r_pos + smap_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // ---------------------------------------------------------------
    // Window: cell k holds the byte seen k+1 requests ago and compares it
    // with pattern byte (len-1)-(k+1). Cells past the pattern pass.
    // ---------------------------------------------------------------
    logic [7:0]                    w_win [smap_pkg::WIN_DEPTH];
    logic [smap_pkg::WIN_DEPTH-1:0] w_hit;

    for (genvar k = 0; k < smap_pkg::WIN_DEPTH; k++) begin : g_cell
        logic [7:0]                 w_in_byte;
        logic [smap_pkg::IDX_W-1:0] w_pidx;
        logic [7:0]                 w_pat_byte;
        logic                       w_active;

        if (k == 0) begin : g_head
            assign w_in_byte = i_in_req.char_in;
        end else begin : g_body
            assign w_in_byte = w_win[k-1];
        end

        assign w_pidx     = w_lenm1 - smap_pkg::IDX_W'(k + 1);
        assign w_pat_byte = r_pat[{w_pidx, 3'b000} +: 8];
        assign w_active   = smap_pkg::IDX_W'(k) < w_lenm1;

        smap_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_byte     (w_in_byte),
            .i_pat_byte (w_pat_byte),
            .i_active   (w_active),
            .o_byte     (w_win[k]),
            .o_hit      (w_hit[k])
        );
    end

    // ---------------------------------------------------------------
    // Match decision: the incoming byte must equal the pattern's last byte,
    // every active cell must hit, and the line must already hold len-1 bytes
    // so zeroed window slack never joins a match.
    // ---------------------------------------------------------------
    logic [7:0] w_last_pat;
    logic       w_found;

    assign w_last_pat = r_pat[{w_lenm1, 3'b000} +: 8];
    assign w_found    = (r_pos >= smap_pkg::POS_W'(w_lenm1))
                        && (i_in_req.char_in == w_last_pat)
                        && (&w_hit);

    smap_pkg::t_out_req r_out;
    smap_pkg::t_out_req n_out;

    always_comb begin
        n_out.match_found = w_found;
        n_out.match_start = w_found ? (r_pos - smap_pkg::POS_W'(w_lenm1)) : '0;
        n_out.line_done   = i_in_req.end_of_line;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_acc) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload: loaded on each accepted request
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_eol_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in_req.end_of_line |=> r_pos == '0)
        else $error("position not cleared after end of line");

    a_pos_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.shift && (r_pos != smap_pkg::POS_MAX)
        |=> r_pos == $past(r_pos) + smap_pkg::POS_W'(1))
        else $error("position did not advance");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (r_len <= smap_pkg::LEN_W'(smap_pkg::MAX_PATTERN)))
        else $error("pattern length out of range");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

    a_found_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_found |-> r_pos >= smap_pkg::POS_W'(w_lenm1))
        else $error("match reported before line holds the pattern");

endmodule
